// ----- sv/qte_pkg.sv -----
// Quaternion to Euler converter: shared widths, constants and helpers.
// Holds the CORDIC arctangent table and the Q3.30 to Q3.13 rounding.
// No dependencies.
package qte_pkg;

  localparam int QW   = 16;
  localparam int PW   = 32;
  localparam int PRW  = 32;
  localparam int NW   = 34;
  localparam int DW   = 33;
  localparam int SW   = 30;
  localparam int RADW = 57;
  localparam int SQW  = 29;
  localparam int OW   = 34;
  localparam int CW   = 38;
  localparam int ZW   = 34;
  localparam int RW   = 17;
  localparam int AXW  = 16;
  localparam int AYW  = 15;

  localparam logic signed [NW-1:0] ONE_Q28   = NW'(64'sd268435456);
  localparam logic signed [ZW-1:0] HALF_PI   = ZW'(64'sd1686629713);
  localparam logic signed [RW-1:0] LIM_XZ    = RW'(25736);
  localparam logic signed [RW-1:0] LIM_Y     = RW'(12868);
  localparam logic [RADW-1:0]      ONE_SQ    = {1'b1, {(RADW-1){1'b0}}};

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(843314856);
      1:  v = ZW'(497837829);
      2:  v = ZW'(263043836);
      3:  v = ZW'(133525158);
      4:  v = ZW'(67021686);
      5:  v = ZW'(33543515);
      6:  v = ZW'(16775850);
      7:  v = ZW'(8388437);
      8:  v = ZW'(4194282);
      9:  v = ZW'(2097149);
      10: v = ZW'(1048575);
      11: v = ZW'(524287);
      12: v = ZW'(262143);
      13: v = ZW'(131071);
      14: v = ZW'(65535);
      15: v = ZW'(32767);
      16: v = ZW'(16383);
      17: v = ZW'(8191);
      18: v = ZW'(4095);
      19: v = ZW'(2047);
      20: v = ZW'(1023);
      21: v = ZW'(511);
      22: v = ZW'(255);
      23: v = ZW'(127);
      24: v = ZW'(63);
      25: v = ZW'(31);
      26: v = ZW'(15);
      27: v = ZW'(7);
      28: v = ZW'(3);
      29: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [RW-1:0] to_q13(input logic signed [ZW-1:0] a,
                                                  input logic signed [RW-1:0] lim);
    logic signed [ZW-1:0] sum;
    logic signed [RW-1:0] r;
    sum = a + ZW'(65536);
    r   = sum[ZW-1:ZW-RW];
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

// ----- sv/qte_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on qte_pkg for widths.
module qte_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [qte_pkg::RADW-1:0]     rad_i,
  output logic [qte_pkg::SQW-1:0]      root_o
);

  localparam int TW = qte_pkg::RADW + 2;

  logic [qte_pkg::RADW-1:0] rem_q  [qte_pkg::SQW];
  logic [qte_pkg::SQW-1:0]  root_q [qte_pkg::SQW];

  for (genvar j = 0; j < qte_pkg::SQW; j++) begin : g_step
    localparam int K = qte_pkg::SQW - 1 - j;
    logic [qte_pkg::RADW-1:0] rem_in;
    logic [qte_pkg::SQW-1:0]  root_in;
    logic [TW-1:0]            term;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign term = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (TW'(rem_in) >= term) begin
          rem_q[j]  <= rem_in - term[qte_pkg::RADW-1:0];
          root_q[j] <= root_in | (qte_pkg::SQW'(1) << K);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[qte_pkg::SQW-1];

endmodule

// ----- sv/qte_cordic.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) in Q3.30 with quarter-turn prerotation.
// Depends on qte_pkg for widths and the arctangent table.
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [qte_pkg::OW-1:0]    y_i,
  input  logic signed [qte_pkg::OW-1:0]    x_i,
  output logic signed [qte_pkg::ZW-1:0]    ang_o,
  output logic                             zero_o
);

  logic signed [qte_pkg::CW-1:0] x_q [STAGES+1];
  logic signed [qte_pkg::CW-1:0] y_q [STAGES+1];
  logic signed [qte_pkg::ZW-1:0] z_q [STAGES+1];
  logic                          zero_q [STAGES+1];

  logic signed [qte_pkg::CW-1:0] xe, ye, x0, y0;
  logic signed [qte_pkg::ZW-1:0] z0;

  always_comb begin
    xe = qte_pkg::CW'(x_i);
    ye = qte_pkg::CW'(y_i);
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = qte_pkg::HALF_PI;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -qte_pkg::HALF_PI;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + qte_pkg::atan_tab(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - qte_pkg::atan_tab(i);
        end
      end
    end
  end

  assign ang_o  = z_q[STAGES];
  assign zero_o = zero_q[STAGES];

endmodule

// ----- sv/quaternion_to_euler.sv -----
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on qte_pkg, qte_sqrt and qte_cordic.
//
// Accepts one pose per clock while the output is not stalled and returns its result
// after a product stage, a sum stage, a 1 - s*s stage, 29 square-root stages, one
// prerotation stage, CORDIC_STAGES rotation stages and a rounding stage. All
// stages advance together; while a result beat waits at the output the whole
// pipeline holds, so in_ready_o follows out_ready_i whenever the output is full.
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] pos_x_in_i,
  input  logic signed [31:0] pos_y_in_i,
  input  logic signed [31:0] pos_z_in_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] pos_x_out_o,
  output logic signed [31:0] pos_y_out_o,
  output logic signed [31:0] pos_z_out_o,
  output logic signed [15:0] angle_about_x_o,
  output logic signed [14:0] angle_about_y_o,
  output logic signed [15:0] angle_about_z_o,
  output logic        asin_clamped_o
);

  localparam int LAT = CORDIC_STAGES + 34;
  localparam int NW  = qte_pkg::NW;
  localparam int DW  = qte_pkg::DW;
  localparam int SW  = qte_pkg::SW;
  localparam int OW  = qte_pkg::OW;
  localparam int ZW  = qte_pkg::ZW;
  localparam int RW  = qte_pkg::RW;
  localparam int PRW = qte_pkg::PRW;

  typedef struct packed {
    logic signed [NW-1:0] axn;
    logic signed [DW-1:0] axd;
    logic signed [NW-1:0] azn;
    logic signed [DW-1:0] azd;
    logic signed [SW-1:0] s;
  } ops_t;

  logic adv;
  logic [LAT-1:0] vld_q;

  logic [3*qte_pkg::PW-1:0] pd_q [LAT-1];
  logic                     cl_q [LAT-2];

  logic signed [PRW-1:0] xx_q, yy_q, zz_q, ww_q, yz_q, xw_q, xy_q, zw_q, yw_q, xz_q;
  ops_t s2_q, s3_q;
  ops_t dl_q [qte_pkg::SQW];
  logic [qte_pkg::RADW-1:0] rad_q;

  logic signed [NW-1:0] s_raw;
  logic signed [NW-1:0] s_cl;
  logic                 clamp_d;
  logic signed [2*SW-1:0] sq;

  logic [qte_pkg::SQW-1:0] root;
  logic signed [ZW-1:0] ang_x, ang_y, ang_z;
  logic zero_x, zero_y, zero_z;
  logic signed [RW-1:0] rx, ry, rz;

  assign adv        = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_q[0] <= {pos_x_in_i, pos_y_in_i, pos_z_in_i};
      for (int k = 1; k < LAT - 1; k++) begin
        pd_q[k] <= pd_q[k-1];
      end
      cl_q[0] <= clamp_d;
      for (int k = 1; k < LAT - 2; k++) begin
        cl_q[k] <= cl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      ww_q <= quat_w_i * quat_w_i;
      yz_q <= quat_y_i * quat_z_i;
      xw_q <= quat_x_i * quat_w_i;
      xy_q <= quat_x_i * quat_y_i;
      zw_q <= quat_z_i * quat_w_i;
      yw_q <= quat_y_i * quat_w_i;
      xz_q <= quat_x_i * quat_z_i;
    end
  end

  always_comb begin
    s_raw   = (NW'(yw_q) - NW'(xz_q)) <<< 1;
    s_cl    = s_raw;
    clamp_d = 1'b0;
    if (s_raw > qte_pkg::ONE_Q28) begin
      s_cl    = qte_pkg::ONE_Q28;
      clamp_d = 1'b1;
    end else if (s_raw < -qte_pkg::ONE_Q28) begin
      s_cl    = -qte_pkg::ONE_Q28;
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q.axn <= (NW'(yz_q) + NW'(xw_q)) <<< 1;
      s2_q.azn <= (NW'(xy_q) + NW'(zw_q)) <<< 1;
      s2_q.axd <= DW'(zz_q) + DW'(ww_q) - DW'(xx_q) - DW'(yy_q);
      s2_q.azd <= DW'(xx_q) + DW'(ww_q) - DW'(yy_q) - DW'(zz_q);
      s2_q.s   <= s_cl[SW-1:0];
    end
  end

  assign sq = s2_q.s * s2_q.s;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q  <= s2_q;
      rad_q <= qte_pkg::ONE_SQ - sq[qte_pkg::RADW-1:0];
      dl_q[0] <= s3_q;
      for (int k = 1; k < qte_pkg::SQW; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  qte_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .y_i    (OW'(dl_q[qte_pkg::SQW-1].axn)),
    .x_i    (OW'(dl_q[qte_pkg::SQW-1].axd)),
    .ang_o  (ang_x),
    .zero_o (zero_x)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .y_i    (OW'(dl_q[qte_pkg::SQW-1].s)),
    .x_i    (signed'(OW'(root))),
    .ang_o  (ang_y),
    .zero_o (zero_y)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
    .clk_i  (clk_i),
    .en_i   (adv),
    .y_i    (OW'(dl_q[qte_pkg::SQW-1].azn)),
    .x_i    (OW'(dl_q[qte_pkg::SQW-1].azd)),
    .ang_o  (ang_z),
    .zero_o (zero_z)
  );

  assign rx = zero_x ? '0 : qte_pkg::to_q13(ang_x, qte_pkg::LIM_XZ);
  assign ry = zero_y ? '0 : qte_pkg::to_q13(ang_y, qte_pkg::LIM_Y);
  assign rz = zero_z ? '0 : qte_pkg::to_q13(ang_z, qte_pkg::LIM_XZ);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {pos_x_out_o, pos_y_out_o, pos_z_out_o} <= pd_q[LAT-2];
      asin_clamped_o  <= cl_q[LAT-3];
      angle_about_x_o <= rx[qte_pkg::AXW-1:0];
      angle_about_y_o <= ry[qte_pkg::AYW-1:0];
      angle_about_z_o <= rz[qte_pkg::AXW-1:0];
    end
  end

  assign out_valid_o = vld_q[LAT-1];

endmodule

// ----- sv/qte_checker.sv -----
// Port-level checks for quaternion_to_euler, bound to the top level.
// Depends on the top level's port names only.
module qte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] pos_x_out_o,
  input logic signed [15:0] angle_about_x_o,
  input logic signed [14:0] angle_about_y_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_out_o)
                                    && $stable(angle_about_y_o))
    else $error("result beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_about_y_o <= 15'sd12868 && angle_about_y_o >= -15'sd12868)
    else $error("angle about y out of range");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_about_x_o <= 16'sd25736 && angle_about_x_o >= -16'sd25736)
    else $error("angle about x out of range");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .pos_x_out_o     (pos_x_out_o),
  .angle_about_x_o (angle_about_x_o),
  .angle_about_y_o (angle_about_y_o)
);
